FILE: src/fan_duty_mode_controller_core_macros.svh
// assertion macros used by the fan duty mode controller top level
`ifndef FAN_DUTY_MODE_CONTROLLER_CORE_MACROS_SVH
`define FAN_DUTY_MODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FDMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FDMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fdmc_pkg.sv
// types, constants and helper functions of the fan duty mode controller
package fdmc_pkg;

  localparam int unsigned TDATA_W = 40;

  localparam logic [15:0] SEC_LIMIT    = 16'd65435;
  // x / 1000 == (x * DIV_MUL) >> DIV_SHIFT for every 32-bit x
  localparam logic [28:0] DIV_MUL      = 29'd274877907;
  localparam int unsigned DIV_SHIFT    = 38;
  localparam int unsigned SEC_W        = 23;

  localparam logic [31:0] EVAL_INTERVAL_RST = 32'd1000;
  localparam logic [31:0] MIN_OFF_RST       = 32'd600000;
  localparam logic [31:0] MAX_ON_RST        = 32'd600000;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_AUTO = 2'd1,
    MODE_ON   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_EVAL_INTERVAL = 2'd0,
    REG_MIN_OFF       = 2'd1,
    REG_MAX_ON        = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_MODE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [31:0] eval_interval_ms;
    logic [31:0] min_off_ms;
    logic [31:0] max_on_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] now_ms;
    logic        ventilation_useful;
  } item_t;

  typedef struct packed {
    logic        running;
    mode_t       mode;
    logic [31:0] last_eval_time;
    logic [31:0] last_switch_time;
    logic [15:0] on_count;
    logic [15:0] off_count;
  } state_t;

  typedef struct packed {
    logic [15:0] off_seconds;
    logic [15:0] on_seconds;
    logic [1:0]  user_mode;
    logic        fan_on;
  } result_t;

  function automatic logic [SEC_W-1:0] ms_to_sec(input logic [31:0] ms);
    logic [60:0] prod;
    prod = {29'b0, ms} * {32'b0, DIV_MUL};
    return prod[DIV_SHIFT +: SEC_W];
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] count,
                                          input logic [SEC_W-1:0] sec);
    logic [SEC_W:0] sum;
    sum = {{(SEC_W-15){1'b0}}, count} + {1'b0, sec};
    return (sum > (SEC_W+1)'(SEC_LIMIT)) ? SEC_LIMIT : sum[15:0];
  endfunction

endpackage

FILE: src/fdmc_in_stage.sv
// input register holding one item until the update logic takes it
module fdmc_in_stage import fdmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  item_t       in_item,
  input  logic        out_room,
  output logic        advance,
  output item_t       item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign advance   = valid_r && out_room;
  assign in_tready = !valid_r || advance;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: src/fdmc_update.sv
// next-state and result logic for one item
module fdmc_update import fdmc_pkg::*; (
  input  state_t  st,
  input  item_t   item,
  input  cfg_t    cfg,
  output state_t  st_nxt,
  output result_t res
);

  logic [31:0]      since_eval;
  logic [31:0]      since_switch;
  logic [SEC_W-1:0] elapsed_sec;
  logic             want_on;

  assign since_eval   = item.now_ms - st.last_eval_time;
  assign since_switch = item.now_ms - st.last_switch_time;
  assign elapsed_sec  = ms_to_sec(since_eval);
  assign want_on      = (st.mode == MODE_ON) ||
                        ((st.mode == MODE_AUTO) && item.ventilation_useful);

  always_comb begin
    st_nxt = st;
    if (item.cmd == CMD_MODE) begin
      unique case (st.mode)
        MODE_OFF:  st_nxt.mode = MODE_AUTO;
        MODE_AUTO: st_nxt.mode = MODE_ON;
        default:   st_nxt.mode = MODE_OFF;
      endcase
      st_nxt.last_switch_time = st.last_switch_time - cfg.min_off_ms;
    end else if (since_eval >= cfg.eval_interval_ms) begin
      st_nxt.last_eval_time = item.now_ms;
      if (!st.running) begin
        st_nxt.off_count = sat_add(st.off_count, elapsed_sec);
        if (since_switch >= cfg.min_off_ms && want_on) begin
          st_nxt.running          = 1'b1;
          st_nxt.off_count        = '0;
          st_nxt.last_switch_time = item.now_ms;
        end
      end else begin
        st_nxt.on_count = sat_add(st.on_count, elapsed_sec);
        if (st.mode == MODE_OFF || since_switch >= cfg.max_on_ms) begin
          st_nxt.running          = 1'b0;
          st_nxt.on_count         = '0;
          st_nxt.last_switch_time = item.now_ms;
        end
      end
    end
  end

  // fan_on reports the state from before the item
  assign res.fan_on      = st.running;
  assign res.user_mode   = st_nxt.mode;
  assign res.on_seconds  = st_nxt.on_count;
  assign res.off_seconds = st_nxt.off_count;

endmodule

FILE: src/fdmc_out_stage.sv
// result register on the output stream
module fdmc_out_stage import fdmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  result_t            res,
  output logic               room,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {(TDATA_W - $bits(result_t))'(0), res_r};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

endmodule

FILE: src/fan_duty_mode_controller_core.sv
// top level of the fan duty mode controller
// One result per input item, one item per cycle sustained while out_tready
// holds. An item is captured in an input register; once the result register
// is free or being emptied, the update logic (two wrapping 32-bit
// differences, a divide by 1000 done as a constant multiply, a saturating
// add and the switch compares) writes the fan state and the result
// register together, so each result passes the input and result registers.
// in_tuser carries the item kind: 0 step, 1 advance the user
// mode (off, auto, on, off). Configuration writes take effect at once and
// are meant for idle periods.
`include "fan_duty_mode_controller_core_macros.svh"

module fan_duty_mode_controller_core import fdmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // now_ms[31:0], ventilation_useful[32]
  input  logic               in_tuser,   // cmd
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // fan_on[0], user_mode[2:1],
                                         // on_seconds[18:3], off_seconds[34:19]
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   in_item;
  item_t   item;
  result_t res;
  logic    advance;
  logic    out_room;

  assign in_item.cmd                = cmd_t'(in_tuser);
  assign in_item.now_ms             = in_tdata[31:0];
  assign in_item.ventilation_useful = in_tdata[32];

  fdmc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .out_room  (out_room),
    .advance   (advance),
    .item      (item)
  );

  fdmc_update u_upd (
    .st     (st_r),
    .item   (item),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  fdmc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .room       (out_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eval_interval_ms <= EVAL_INTERVAL_RST;
      cfg_r.min_off_ms       <= MIN_OFF_RST;
      cfg_r.max_on_ms        <= MAX_ON_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EVAL_INTERVAL: cfg_r.eval_interval_ms <= cfg_wdata;
        REG_MIN_OFF:       cfg_r.min_off_ms       <= cfg_wdata;
        REG_MAX_ON:        cfg_r.max_on_ms        <= cfg_wdata;
        default:           cfg_r                  <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.running          <= 1'b0;
      st_r.mode             <= MODE_AUTO;
      st_r.last_eval_time   <= '0;
      st_r.last_switch_time <= '0;
      st_r.on_count         <= '0;
      st_r.off_count        <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // only the counter of the current fan state may be nonzero
  `FDMC_ASSERT_NOW(a_idle_count_clear, clk, rst_n, 1'b1, (st_r.running ? (st_r.off_count == 16'd0) : (st_r.on_count == 16'd0)), "counter of inactive fan state not cleared")

  `FDMC_ASSERT_NEXT(a_mode_backdate, clk, rst_n, advance && item.cmd == CMD_MODE, st_r.last_switch_time == $past(st_r.last_switch_time - cfg_r.min_off_ms), "mode transfer did not backdate switch time")

  `FDMC_ASSERT_NEXT(a_mode_keeps_counts, clk, rst_n, advance && item.cmd == CMD_MODE, $stable(st_r.on_count) && $stable(st_r.off_count), "mode transfer changed counters")

  `FDMC_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_tvalid, "processed item gave no result")

endmodule

FILE: tb/sv/fan_duty_mode_controller_core_tb.sv
// self-checking testbench for the fan duty mode controller core
module fan_duty_mode_controller_core_tb;
  import fdmc_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic        fan_on;
    logic [1:0]  user_mode;
    logic [15:0] on_seconds;
    logic [15:0] off_seconds;
  } fan_status_t;

  // fan state predictor plus the queue of statuses still owed by the block
  class fan_scoreboard;
    logic [31:0] eval_ms;
    logic [31:0] min_off_ms;
    logic [31:0] max_on_ms;
    logic        running;
    mode_t       mode;
    logic [31:0] last_eval_ms;
    logic [31:0] last_switch_ms;
    logic [15:0] on_sec;
    logic [15:0] off_sec;
    fan_status_t status_q[$];
    int unsigned errors;

    function new();
      eval_ms        = 32'd1000;
      min_off_ms     = 32'd600000;
      max_on_ms      = 32'd600000;
      running        = 1'b0;
      mode           = MODE_AUTO;
      last_eval_ms   = '0;
      last_switch_ms = '0;
      on_sec         = '0;
      off_sec        = '0;
      errors         = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_EVAL_INTERVAL: eval_ms = value;
        REG_MIN_OFF:       min_off_ms = value;
        REG_MAX_ON:        max_on_ms = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // whole seconds added at full width, then clamped
    function logic [15:0] accrue(logic [15:0] count, logic [31:0] elapsed_ms);
      logic [32:0] sum;
      sum = 33'(count) + 33'(elapsed_ms / 32'd1000);
      return (sum > 33'(SEC_LIMIT)) ? SEC_LIMIT : sum[15:0];
    endfunction

    function void note_item(cmd_t cmd, logic [31:0] now, logic useful);
      fan_status_t st;
      logic [31:0] since_eval;
      logic [31:0] since_switch;
      st.fan_on = running;
      if (cmd == CMD_MODE) begin
        case (mode)
          MODE_OFF:  mode = MODE_AUTO;
          MODE_AUTO: mode = MODE_ON;
          default:   mode = MODE_OFF;
        endcase
        // backdate so the next evaluation may start the fan
        last_switch_ms = last_switch_ms - min_off_ms;
      end else begin
        since_eval = now - last_eval_ms;
        if (since_eval >= eval_ms) begin
          since_switch = now - last_switch_ms;
          if (!running) begin
            off_sec = accrue(off_sec, since_eval);
            if (since_switch >= min_off_ms &&
                (mode == MODE_ON || (mode == MODE_AUTO && useful))) begin
              running = 1'b1;
              off_sec = '0;
              last_switch_ms = now;
            end
          end else begin
            on_sec = accrue(on_sec, since_eval);
            if (mode == MODE_OFF || since_switch >= max_on_ms) begin
              running = 1'b0;
              on_sec = '0;
              last_switch_ms = now;
            end
          end
          last_eval_ms = now;
        end
      end
      st.user_mode   = mode;
      st.on_seconds  = on_sec;
      st.off_seconds = off_sec;
      status_q.push_back(st);
    endfunction

    task report(string field, logic [39:0] got, logic [39:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    endtask

    task check_result(logic [TDATA_W-1:0] d);
      fan_status_t want;
      if (status_q.size() == 0) begin
        report("unexpected result", 40'(d), '0);
      end else begin
        want = status_q.pop_front();
        if (d[0] !== want.fan_on)         report("fan_on", 40'(d[0]), 40'(want.fan_on));
        if (d[2:1] !== want.user_mode)    report("user_mode", 40'(d[2:1]), 40'(want.user_mode));
        if (d[18:3] !== want.on_seconds)  report("on_seconds", 40'(d[18:3]),
                                                 40'(want.on_seconds));
        if (d[34:19] !== want.off_seconds) report("off_seconds", 40'(d[34:19]),
                                                  40'(want.off_seconds));
        if (d[TDATA_W-1:35] !== '0)       report("tdata padding", 40'(d[TDATA_W-1:35]), '0);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  fan_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  logic [31:0] clock_ms = '0;

  fan_duty_mode_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_item(cmd_t'(in_tuser), in_tdata[31:0], in_tdata[32]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[fan_duty_mode_controller_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [31:0] now, logic useful);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(TDATA_W-33){1'b0}}, useful, now};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic step_at(logic [31:0] now, logic useful);
    send_item(CMD_STEP, now, useful);
  endtask

  task automatic advance_mode();
    send_item(CMD_MODE, $urandom(), 1'($urandom_range(1, 0)));
  endtask

  // stop offering and wait for every owed status
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ev, logic [31:0] mo, logic [31:0] mx);
    wait_drained();
    write_reg(REG_EVAL_INTERVAL, ev);
    write_reg(REG_MIN_OFF, mo);
    write_reg(REG_MAX_ON, mx);
  endtask

  // mostly monotonic timestamps near the evaluation interval, with mode
  // presses, timestamp jumps and huge gaps that saturate the counters
  task automatic random_burst(int unsigned count);
    int unsigned pick;
    logic [31:0] span;
    logic [31:0] delta;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        advance_mode();
      end else if (pick < 13) begin
        clock_ms = $urandom();
        step_at(clock_ms, 1'($urandom_range(1, 0)));
      end else begin
        span = (sb.eval_ms > 32'd20000) ? 32'd20000 : sb.eval_ms;
        if (pick < 82)
          delta = $urandom_range(2 * span + 1000, 0);
        else if (pick < 95)
          delta = $urandom_range(200000, 0);
        else
          delta = $urandom();
        clock_ms = clock_ms + delta;
        step_at(clock_ms, $urandom_range(99, 0) < 70);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: interval edge, start after min off, timeouts, wrap
    step_at(32'd0, 1'b0);
    step_at(32'd999, 1'b1);
    step_at(32'd1000, 1'b0);
    step_at(32'd600000, 1'b1);
    step_at(32'd601999, 1'b0);
    advance_mode();
    advance_mode();
    step_at(32'd603000, 1'b1);
    advance_mode();
    step_at(ALL_ONES, 1'b1);
    step_at(32'h0000_0FA0, 1'b0);
    step_at(32'hAAAA_AAAA, 1'b1);
    advance_mode();
    step_at(32'h5555_5555, 1'b0);
    advance_mode();
    advance_mode();

    // zero interval and zero times: start and stop on consecutive steps
    configure('0, '0, '0);
    step_at(32'd5, 1'b0);
    step_at(32'd5, 1'b1);
    step_at(32'd6, 1'b0);

    send_idle_pct = 22;
    recv_idle_pct = 50;
    random_burst(130);

    configure(32'd1000, 32'd5000, 32'd8000);
    random_burst(65);
    hold_token <= hold_token + 1;
    random_burst(65);

    configure(32'd500, 32'd0, 32'd3000);
    random_burst(130);

    // all-ones registers: evaluation only at the largest possible gap
    send_idle_pct = 50;
    recv_idle_pct = 22;
    configure(ALL_ONES, ALL_ONES, ALL_ONES);
    step_at(sb.last_eval_ms - 32'd2, 1'b1);
    clock_ms = sb.last_eval_ms - 32'd1;
    step_at(clock_ms, 1'b1);
    random_burst(40);

    configure(32'd250, 32'd2000, 32'd0);
    random_burst(70);
    wait_drained();
    random_burst(70);

    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(3000, 0), $urandom_range(20000, 0),
                $urandom_range(20000, 0));
      if (p > 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_burst(178);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[fan_duty_mode_controller_core] OK");
    else
      $display("[fan_duty_mode_controller_core] ERROR");
    $finish;
  end

endmodule
